FILE: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PTPD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PTPD_ASSERT(label, clk, rst_n, prop)
`define PTPD_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: src/ptpd_pkg.sv
// shared types and codes of the point table distance block
package ptpd_pkg;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_INDEX_W = 6;
    localparam int TOTAL_W       = 29;
    localparam int COUNT_OUT_W   = 7;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic load;
        logic remove;
        logic rotate;
    } t_cell_op;
endpackage

FILE: src/ptpd_cell.sv
// one table cell holding a single point
module ptpd_cell #(
    parameter int COORD_WIDTH = 16,
    parameter int CNT_W       = 7,
    parameter int POS         = 0
) (
    input  logic                          i_clk,
    input  ptpd_pkg::t_cell_op            i_op,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [CNT_W-1:0]              i_index,
    input  logic signed [COORD_WIDTH-1:0] i_new_x,
    input  logic signed [COORD_WIDTH-1:0] i_new_y,
    input  logic signed [COORD_WIDTH-1:0] i_next_x,
    input  logic signed [COORD_WIDTH-1:0] i_next_y,
    input  logic signed [COORD_WIDTH-1:0] i_head_x,
    input  logic signed [COORD_WIDTH-1:0] i_head_y,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y
);
    import ptpd_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(POS);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(POS + 1);

    logic signed [COORD_WIDTH-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_op.load && (i_count == MY_POS)) begin
            r_x <= i_new_x;
            r_y <= i_new_y;
        end else if (i_op.remove && (MY_POS >= i_index) && (MY_NEXT < i_count)) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end else if (i_op.rotate) begin
            if (MY_NEXT < i_count) begin
                r_x <= i_next_x;
                r_y <= i_next_y;
            end else if (MY_NEXT == i_count) begin
                // last live cell closes the ring
                r_x <= i_head_x;
                r_y <= i_head_y;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

FILE: src/ptpd_dist.sv
// pipelined distance unit: difference, squares, sum, bit-per-stage root
module ptpd_dist #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    output logic                          o_valid,
    output logic [COORD_WIDTH:0]          o_root,
    output logic                          o_busy
);
    import ptpd_pkg::*;

    localparam int R  = COORD_WIDTH + 1;
    localparam int SQ = 2 * COORD_WIDTH;

    logic signed [COORD_WIDTH:0] dx_s, dy_s;
    logic [COORD_WIDTH-1:0]      r_dx, r_dy;
    logic [SQ-1:0]               r_sx, r_sy;
    logic                        r_v1, r_v2;
    logic [R+1:0]                r_rem  [0:R];
    logic [R-1:0]                r_root [0:R];
    logic [2*R-1:0]              r_val  [0:R];
    logic [R:0]                  r_v;

    assign dx_s = (COORD_WIDTH+1)'(i_ax) - (COORD_WIDTH+1)'(i_bx);
    assign dy_s = (COORD_WIDTH+1)'(i_ay) - (COORD_WIDTH+1)'(i_by);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v[0]  <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v[0]  <= r_v2;
        end
        r_dx <= dx_s[COORD_WIDTH] ? COORD_WIDTH'(-dx_s) : COORD_WIDTH'(dx_s);
        r_dy <= dy_s[COORD_WIDTH] ? COORD_WIDTH'(-dy_s) : COORD_WIDTH'(dy_s);
        r_sx <= SQ'(r_dx) * SQ'(r_dx);
        r_sy <= SQ'(r_dy) * SQ'(r_dy);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_val[0]  <= (2*R)'(r_sx) + (2*R)'(r_sy);
    end

    // one result bit per stage
    for (genvar s = 1; s <= R; s++) begin : g_root
        logic [R+1:0] rem_sh, trial;
        assign rem_sh = {r_rem[s-1][R-1:0], r_val[s-1][2*R-1:2*R-2]};
        assign trial  = {r_root[s-1], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
            r_val[s] <= {r_val[s-1][2*R-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem[s]  <= rem_sh - trial;
                r_root[s] <= {r_root[s-1][R-2:0], 1'b1};
            end else begin
                r_rem[s]  <= rem_sh;
                r_root[s] <= {r_root[s-1][R-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[R];
    assign o_root  = r_root[R];
    assign o_busy  = r_v1 | r_v2 | (|r_v);
endmodule

FILE: src/point_table_pairwise_distance_sum_core.sv
// top level: point table with pairwise distance sum
//
//  beat     direction  handshake               payload
//  input    in         i_valid / o_stall       i_func, i_point_x, i_point_y, i_entry_index
//  result   out        o_valid / i_stall       o_total_distance, o_point_count, o_status
//
// add, remove and unused codes give their result in the cycle after the beat is taken
// report with n points takes n*(n+1) ring shifts, then waits for the distance pipeline
//   to drain into the result register; the single distance unit is fed one pair a cycle
//   while a pass runs, but not in the gap between passes
// an empty table reports in the cycle after the beat is taken
// reset clears the point count, the sequencer state and the result valid flag; stored points
//   keep whatever they hold
// a stalled result holds the block off new beats only while it is still waiting
module point_table_pairwise_distance_sum_core #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ptpd_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [COORD_WIDTH-1:0]         i_point_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_y,
    input  logic [ptpd_pkg::ENTRY_INDEX_W-1:0]    i_entry_index,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ptpd_pkg::TOTAL_W-1:0]          o_total_distance,
    output logic [ptpd_pkg::COUNT_OUT_W-1:0]      o_point_count,
    output logic [ptpd_pkg::STATUS_W-1:0]         o_status
);
    import ptpd_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IW    = (CNT_W > ENTRY_INDEX_W) ? CNT_W : ENTRY_INDEX_W;
    localparam int R     = COORD_WIDTH + 1;
    localparam int SUM_W = ((TOTAL_W > R) ? TOTAL_W : R) + 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_GAP   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_i, n_i, r_j, n_j;
    logic signed [COORD_WIDTH-1:0] r_anchor_x, r_anchor_y;
    logic [TOTAL_W-1:0]            r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]            r_out_total, n_out_total;
    logic [COUNT_OUT_W-1:0]        r_out_count, n_out_count;
    logic [STATUS_W-1:0]           r_out_status, n_out_status;

    logic                          accept;
    logic                          idx_ok, room;
    logic [CNT_W-1:0]              last;
    t_cell_op                      cell_op;
    logic signed [COORD_WIDTH-1:0] cell_x [0:MAX_POINTS-1];
    logic signed [COORD_WIDTH-1:0] cell_y [0:MAX_POINTS-1];
    logic                          pair_valid;
    logic signed [COORD_WIDTH-1:0] pair_ax, pair_ay;
    logic                          dist_valid, dist_busy;
    logic [R-1:0]                  dist_root;
    logic [SUM_W-1:0]              acc_sum;

    assign o_stall = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign idx_ok  = IW'(i_entry_index) < IW'(r_count);
    assign room    = r_count < CNT_W'(MAX_POINTS);
    assign last    = r_count - CNT_W'(1);

    assign cell_op.load   = accept && (i_func == FUNC_ADD) && room;
    assign cell_op.remove = accept && (i_func == FUNC_REMOVE) && idx_ok;
    assign cell_op.rotate = (r_state == ST_PASS) || (r_state == ST_GAP);

    // row of cells forming a ring over the live entries
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        localparam int NB = (k + 1 < MAX_POINTS) ? k + 1 : k;
        ptpd_cell #(
            .COORD_WIDTH(COORD_WIDTH),
            .CNT_W      (CNT_W),
            .POS        (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_count (r_count),
            .i_index (CNT_W'(i_entry_index)),
            .i_new_x (i_point_x),
            .i_new_y (i_point_y),
            .i_next_x(cell_x[NB]),
            .i_next_y(cell_y[NB]),
            .i_head_x(cell_x[0]),
            .i_head_y(cell_y[0]),
            .o_x     (cell_x[k]),
            .o_y     (cell_y[k])
        );
    end

    // anchor point of a pass is the head at its first cycle
    assign pair_valid = (r_state == ST_PASS);
    assign pair_ax    = (r_j == '0) ? cell_x[0] : r_anchor_x;
    assign pair_ay    = (r_j == '0) ? cell_y[0] : r_anchor_y;

    ptpd_dist #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(pair_valid),
        .i_ax   (pair_ax),
        .i_ay   (pair_ay),
        .i_bx   (cell_x[0]),
        .i_by   (cell_y[0]),
        .o_valid(dist_valid),
        .o_root (dist_root),
        .o_busy (dist_busy)
    );

    assign acc_sum = SUM_W'(r_acc) + SUM_W'(dist_root);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_i          = r_i;
        n_j          = r_j;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && i_stall;
        n_out_total  = r_out_total;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;

        // saturating accumulate of each distance
        if (dist_valid) begin
            n_acc = (acc_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(acc_sum);
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_total  = '0;
                    n_out_status = STATUS_OK;
                    n_out_valid  = 1'b1;
                    case (i_func)
                        FUNC_ADD: begin
                            if (room) begin
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_out_status = STATUS_FULL;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (idx_ok) begin
                                n_count = last;
                            end else begin
                                n_out_status = STATUS_RANGE;
                            end
                        end
                        FUNC_REPORT: begin
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_state     = ST_PASS;
                                n_i         = '0;
                                n_j         = '0;
                                n_acc       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = COUNT_OUT_W'(n_count);
                end
            end
            ST_PASS: begin
                if (r_j == last) begin
                    n_state = ST_GAP;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            ST_GAP: begin
                // extra shift moves the next anchor to the head
                n_j = '0;
                if (r_i == last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_PASS;
                end
            end
            ST_DRAIN: begin
                if (!dist_busy) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_total  = r_acc;
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_out_status = STATUS_OK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i          <= n_i;
        r_j          <= n_j;
        r_acc        <= n_acc;
        r_out_total  <= n_out_total;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
        if ((r_state == ST_PASS) && (r_j == '0)) begin
            r_anchor_x <= cell_x[0];
            r_anchor_y <= cell_y[0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_total_distance = r_out_total;
    assign o_point_count    = r_out_count;
    assign o_status         = r_out_status;

    // checks on the sequencer and table
    `PTPD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_POINTS))
    `PTPD_ASSERT(a_pass_nonempty, i_clk, i_rst_n, (r_state == ST_PASS) |-> (r_count != '0))
    `PTPD_ASSERT(a_dist_in_report, i_clk, i_rst_n, dist_valid |-> (r_state != ST_IDLE))
    `PTPD_ASSERT_NEXT(a_report_start, i_clk, i_rst_n,
        accept && (i_func == FUNC_REPORT) && (r_count != '0), r_state == ST_PASS)
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the point table pairwise distance sum core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ptpd_pkg::*;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // scoreboard: keeps its own copy of the point table and predicts every result beat
    class distance_scoreboard;
        logic signed [15:0] xs[64];
        logic signed [15:0] ys[64];
        int unsigned        held;
        logic [TOTAL_W-1:0]     exp_total[$];
        logic [COUNT_OUT_W-1:0] exp_count[$];
        logic [STATUS_W-1:0]    exp_status[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            held = 0;
            errors = 0;
            checked = 0;
        endfunction

        // floor square root, bit by bit
        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 20;
            while (b != 0) begin
                if ((r + b) * (r + b) <= v) r = r + b;
                b = b >> 1;
            end
            return r;
        endfunction

        function automatic void note_beat(logic [1:0] fn, logic signed [15:0] px,
                                          logic signed [15:0] py, logic [5:0] ix);
            longint unsigned sum;
            longint signed dx;
            longint signed dy;
            logic [1:0] st;
            sum = 0;
            st = STATUS_OK;
            if (fn == FUNC_ADD) begin
                if (held >= 64) st = STATUS_FULL;
                else begin
                    xs[held] = px;
                    ys[held] = py;
                    held++;
                end
            end else if (fn == FUNC_REMOVE) begin
                if (ix >= held) st = STATUS_RANGE;
                else begin
                    for (int k = ix; k + 1 < held; k++) begin
                        xs[k] = xs[k+1];
                        ys[k] = ys[k+1];
                    end
                    held--;
                end
            end else if (fn == FUNC_REPORT) begin
                for (int i = 0; i < held; i++)
                    for (int j = 0; j < held; j++) begin
                        dx = longint'(xs[i]) - longint'(xs[j]);
                        dy = longint'(ys[i]) - longint'(ys[j]);
                        sum += root_floor(dx * dx + dy * dy);
                        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
                    end
            end
            exp_total = {exp_total, sum[TOTAL_W-1:0]};
            exp_count = {exp_count, held[COUNT_OUT_W-1:0]};
            exp_status = {exp_status, st};
        endfunction

        function automatic void check_result(logic [TOTAL_W-1:0] t,
                                             logic [COUNT_OUT_W-1:0] c, logic [1:0] s);
            logic [TOTAL_W-1:0] et;
            logic [COUNT_OUT_W-1:0] ec;
            logic [1:0] es;
            checked++;
            if (exp_total.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: total %0d count %0d", t, c);
                return;
            end
            et = exp_total.pop_front();
            ec = exp_count.pop_front();
            es = exp_status.pop_front();
            if (t !== et || c !== ec || s !== es) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: total %0d/%0d count %0d/%0d status %0d/%0d (exp/act)",
                             et, t, ec, c, es, s);
            end
        endfunction

        function automatic int unsigned waiting();
            return exp_total.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [FUNC_W-1:0]        i_func = FUNC_ADD;
    logic signed [15:0]       i_point_x = '0;
    logic signed [15:0]       i_point_y = '0;
    logic [ENTRY_INDEX_W-1:0] i_entry_index = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [TOTAL_W-1:0]       o_total_distance;
    logic [COUNT_OUT_W-1:0]   o_point_count;
    logic [STATUS_W-1:0]      o_status;

    distance_scoreboard board = new();

    // idle rates in percent, changed per phase
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          hold_off = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned reports_sent = 0;

    always #5 i_clk = ~i_clk;

    point_table_pairwise_distance_sum_core u_dut (.*);

    // receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            board.check_result(o_total_distance, o_point_count, o_status);
        i_stall <= hold_off || ($urandom_range(99) < recv_idle);
    end

    // one beat offered and held until taken, with optional random idling before it
    task automatic send_beat(logic [1:0] fn, logic signed [15:0] px,
                             logic signed [15:0] py, logic [5:0] ix);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_point_x <= px;
        i_point_y <= py;
        i_entry_index <= ix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_beat(fn, px, py, ix);
        beats_sent++;
        if (fn == FUNC_REPORT) reports_sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // pause the sender until every result is back
    task automatic drain();
        go_idle();
        while (board.waiting() != 0) @(posedge i_clk);
    endtask

    // mostly adds and reports on a small table, with removes and the odd unused code
    task automatic random_beat();
        int unsigned pick;
        logic [1:0] fn;
        pick = $urandom_range(99);
        if (pick < 45 && board.held < 12) fn = FUNC_ADD;
        else if (pick < 70) fn = FUNC_REMOVE;
        else if (pick < 95) fn = FUNC_REPORT;
        else if (pick < 97) fn = FUNC_UNUSED;
        else fn = FUNC_ADD;
        send_beat(fn, 16'($urandom), 16'($urandom),
                  ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(board.held)));
    endtask

    initial begin
        #20ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, range errors, extremes, unused code
        send_beat(FUNC_REPORT, 0, 0, 0);
        send_beat(FUNC_REMOVE, 0, 0, 0);
        send_beat(FUNC_ADD, 16'sh7fff, 16'sh7fff, 0);
        send_beat(FUNC_REPORT, 0, 0, 0);
        send_beat(FUNC_ADD, 16'sh8000, 16'sh8000, 0);
        send_beat(FUNC_ADD, 16'sh8000, 16'sh7fff, 0);
        send_beat(FUNC_ADD, 0, -1, 0);
        send_beat(FUNC_REPORT, 0, 0, 0);
        send_beat(FUNC_UNUSED, 16'sh5555, 16'shaaaa, 6'h3f);
        send_beat(FUNC_REMOVE, 0, 0, 6'h3f);
        send_beat(FUNC_REMOVE, 0, 0, 3);
        send_beat(FUNC_REMOVE, 0, 0, 1);
        send_beat(FUNC_REPORT, 0, 0, 0);
        send_beat(FUNC_REMOVE, 0, 0, 0);
        send_beat(FUNC_REMOVE, 0, 0, 0);
        send_beat(FUNC_REPORT, 0, 0, 0);
        drain();

        // fill the table to the limit, one dropped add, one full report, two removes
        while (board.held < 64)
            send_beat(FUNC_ADD, 16'($urandom), 16'($urandom), 0);
        send_beat(FUNC_ADD, 16'sh1234, 16'sh4321, 0);
        send_beat(FUNC_REPORT, 0, 0, 0);
        send_beat(FUNC_REMOVE, 0, 0, 63);
        send_beat(FUNC_REMOVE, 0, 0, 6'h2a);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (5000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6) random_beat();
        join
        drain();

        send_idle = 15;
        recv_idle = 59;
        repeat (15) random_beat();
        drain();
        send_idle = 59;
        recv_idle = 15;
        repeat (15) random_beat();
        drain();
        send_idle = 0;
        recv_idle = 0;
        repeat (15) random_beat();
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d beats, %0d reports, %0d results checked",
                 beats_sent, reports_sent, board.checked);
        if (board.errors == 0 && board.waiting() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/ptpd_pkg.sv
src/ptpd_cell.sv
src/ptpd_dist.sv
src/point_table_pairwise_distance_sum_core.sv
tb/testbench.sv
